// File: rtl/assert_macros.svh
// Assertion helpers, clocked on clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/rlfe_pkg.sv
`default_nettype none
package rlfe_pkg;

   localparam int MAX_LEDS_DEF = 32;
   localparam int CHANNELS     = 3;
   localparam int COLOR_W      = 8;
   localparam int DELTA_W      = 9;
   localparam int PER_W        = 15;
   localparam int ACC_W        = 17;
   localparam int IDX_W        = 5;
   localparam int LEDCFG_W     = 6;
   localparam int CNT_W        = 7;
   localparam int LEDS_RESET   = 32;

   typedef enum logic [2:0] {
      ACT_FADE     = 3'd0,
      ACT_REDIRECT = 3'd1,
      ACT_YANK     = 3'd2,
      ACT_SET      = 3'd3,
      ACT_TICK     = 3'd4
   } action_type;

   typedef struct packed {
      action_type                            kind;
      logic [IDX_W-1:0]                      led;
      logic [PER_W-1:0]                      ticks;
      logic [CHANNELS-1:0][COLOR_W-1:0]      col;
   } item_type;

   typedef struct packed {
      logic [CHANNELS-1:0][COLOR_W-1:0]      cur;
      logic [CHANNELS-1:0][COLOR_W-1:0]      tgt;
      logic [CHANNELS-1:0][DELTA_W-1:0]      dlt;
      logic [PER_W-1:0]                      per;
      logic [CHANNELS-1:0][ACC_W-1:0]        acc;
   } row_type;

   typedef struct packed {
      logic [IDX_W-1:0]                      led;
      logic [CHANNELS-1:0][COLOR_W-1:0]      col;
      logic                                  changed;
      logic                                  done;
      logic                                  last;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_stat_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_CMD,
      ST_CH,
      ST_DIV,
      ST_APPLY,
      ST_FIN
   } back_state_type;

endpackage
`default_nettype wire

// File: rtl/rlfe_front.sv
`default_nettype none
module rlfe_front
   import rlfe_pkg::*;
#(
   parameter int NW = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [NW-1:0]    n_leds,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [2:0]       in_action,
   input  wire logic [IDX_W-1:0] in_led,
   input  wire logic [PER_W-1:0] in_ticks,
   input  wire logic [CHANNELS-1:0][COLOR_W-1:0] in_col,
   output logic                  q_valid,
   output item_type              q_item,
   input  wire logic             q_pop
);

   item_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep, push;
   item_type   new_item;

   always_comb begin
      keep = 1'b0;
      if ((in_action == ACT_FADE) || (in_action == ACT_REDIRECT) ||
          (in_action == ACT_YANK) || (in_action == ACT_SET)) begin
         keep = CNT_W'(in_led) < CNT_W'(n_leds);
      end else if (in_action == ACT_TICK) begin
         keep = n_leds != '0;
      end
      new_item.kind  = action_type'(in_action);
      new_item.led   = in_led;
      new_item.ticks = in_ticks;
      new_item.col   = in_col;
   end

   assign in_ready = count_ff != 2'd2;
   assign push     = in_valid && in_ready && keep;
   assign q_valid  = count_ff != 2'd0;
   assign q_item   = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/rlfe_div.sv
`default_nettype none
module rlfe_div
   import rlfe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [ACC_W-1:0] dividend,
   input  wire logic [PER_W-1:0] divisor,
   output logic                  done,
   output logic [ACC_W-1:0]      quot,
   output logic [PER_W-1:0]      rem
);

   localparam int CW = $clog2(ACC_W + 1);

   logic [ACC_W-1:0] quo_ff, quo_in;
   logic [PER_W-1:0] rem_ff, rem_in;
   logic [PER_W-1:0] dsr_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [PER_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[ACC_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CW'(ACC_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[ACC_W-2:0], ge};
         rem_in  = ge ? PER_W'(trial - {1'b0, dsr_ff}) : trial[PER_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// File: rtl/rlfe_back.sv
`default_nettype none
module rlfe_back
   import rlfe_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF,
   parameter int NW       = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [NW-1:0] n_leds,
   input  wire logic          q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               out_valid,
   input  wire logic          out_ready,
   output result_type         out_data,
   output back_stat_type      stat
);

   localparam int LW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   back_state_type state_ff, state_in;
   row_type        mem [MAX_LEDS];
   row_type        rdata_ff;
   row_type        row_ff;
   row_type        wdata;
   row_type        cmd_row;
   item_type       item_ff;
   logic [LW-1:0]  clr_ff;
   logic [LW-1:0]  led_ff;
   logic [1:0]     ch_ff;
   logic           moving_ff;
   logic           neg_ff;
   logic           mem_we;
   logic [LW-1:0]  waddr;
   logic           last_ch, clr_last, is_last, out_free, emit;
   logic           all_eq, done_flag;
   logic           out_valid_ff;
   result_type     out_data_ff;

   logic signed [ACC_W:0] s_sum;
   logic [ACC_W-1:0]      s_mag;
   logic                  div_start, div_done;
   logic [ACC_W-1:0]      quot;
   logic [PER_W-1:0]      rem;
   logic [ACC_W:0]        k;
   logic [PER_W-1:0]      news;
   logic [COLOR_W-1:0]    c, d, diff;
   logic                  toward;

   rlfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (s_mag),
      .divisor  (row_ff.per),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   always_comb begin
      c       = row_ff.cur[ch_ff];
      d       = row_ff.tgt[ch_ff];
      s_sum   = $signed({row_ff.acc[ch_ff][ACC_W-1], row_ff.acc[ch_ff]}) +
                $signed({{(ACC_W+1-DELTA_W){row_ff.dlt[ch_ff][DELTA_W-1]}},
                         row_ff.dlt[ch_ff]});
      s_mag   = s_sum[ACC_W] ? ACC_W'(-s_sum) : ACC_W'(s_sum);
      diff    = (c > d) ? c - d : d - c;
      toward  = neg_ff ? (c > d) : (c < d);
      k       = neg_ff ? ((ACC_W+1)'(quot) + (ACC_W+1)'(rem != '0)) : (ACC_W+1)'(quot);
      news    = neg_ff ? ((rem == '0) ? '0 : row_ff.per - rem) : rem;
      last_ch = ch_ff == 2'(CHANNELS - 1);
      clr_last = CNT_W'(clr_ff) == CNT_W'(MAX_LEDS - 1);
      is_last = (CNT_W'(led_ff) + CNT_W'(1)) == CNT_W'(n_leds);
      out_free = !out_valid_ff || out_ready;
      all_eq  = row_ff.cur == row_ff.tgt;
      done_flag = moving_ff && all_eq;
   end

   always_comb begin
      cmd_row = row_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         unique case (item_ff.kind)
            ACT_FADE, ACT_REDIRECT: begin
               cmd_row.tgt[i] = item_ff.col[i];
               cmd_row.dlt[i] = DELTA_W'({1'b0, item_ff.col[i]} - {1'b0, row_ff.cur[i]});
            end
            ACT_YANK: begin
               cmd_row.cur[i] = item_ff.col[i];
               cmd_row.dlt[i] = DELTA_W'({1'b0, row_ff.tgt[i]} - {1'b0, item_ff.col[i]});
            end
            default: begin
               cmd_row.cur[i] = item_ff.col[i];
               cmd_row.tgt[i] = item_ff.col[i];
               cmd_row.dlt[i] = '0;
            end
         endcase
      end
      if (item_ff.kind == ACT_FADE) begin
         cmd_row.per = (item_ff.ticks == '0) ? PER_W'(1) : item_ff.ticks;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (q_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = (item_ff.kind == ACT_TICK) ? ST_CH : ST_CMD;
         ST_CMD:   state_in = ST_IDLE;
         ST_CH: begin
            if (row_ff.per == '0) begin
               state_in = ST_FIN;
            end else if (c == d) begin
               state_in = last_ch ? ST_FIN : ST_CH;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:   if (div_done) state_in = ST_APPLY;
         ST_APPLY: state_in = last_ch ? ST_FIN : ST_CH;
         ST_FIN:   if (out_free) state_in = is_last ? ST_IDLE : ST_READ;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      waddr     = led_ff;
      wdata     = row_ff;
      div_start = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
         end
         ST_IDLE:  q_pop = q_valid;
         ST_CMD: begin
            mem_we = 1'b1;
            wdata  = cmd_row;
         end
         ST_CH:    div_start = (row_ff.per != '0) && (c != d);
         ST_FIN: begin
            mem_we = 1'b1;
            if (done_flag) begin
               wdata.acc = '0;
            end
            emit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[led_ff];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            item_ff <= q_item;
            led_ff  <= (q_item.kind == ACT_TICK) ? '0 : LW'(q_item.led);
         end
         ST_LOAD: begin
            row_ff    <= rdata_ff;
            ch_ff     <= '0;
            moving_ff <= 1'b0;
         end
         ST_CH: begin
            neg_ff <= s_sum[ACC_W];
            if ((row_ff.per != '0) && (c == d)) begin
               ch_ff <= ch_ff + 2'd1;
            end
         end
         ST_APPLY: begin
            moving_ff <= 1'b1;
            ch_ff     <= ch_ff + 2'd1;
            if (toward && (k >= (ACC_W+1)'(diff))) begin
               row_ff.cur[ch_ff] <= d;
               row_ff.acc[ch_ff] <= '0;
            end else begin
               row_ff.acc[ch_ff] <= ACC_W'(news);
               if (toward) begin
                  row_ff.cur[ch_ff] <= neg_ff ? c - k[COLOR_W-1:0] : c + k[COLOR_W-1:0];
               end
            end
         end
         ST_FIN: begin
            if (out_free && !is_last) begin
               led_ff <= led_ff + LW'(1);
            end
         end
         default: begin
         end
      endcase
      if (emit) begin
         out_data_ff.led     <= IDX_W'(led_ff);
         out_data_ff.col     <= row_ff.cur;
         out_data_ff.changed <= moving_ff;
         out_data_ff.done    <= done_flag;
         out_data_ff.last    <= is_last;
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + LW'(1);
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_data      = out_data_ff;
   assign stat.clearing = state_ff == ST_CLEAR;
   assign stat.busy     = state_ff != ST_IDLE;

endmodule
`default_nettype wire

// File: rtl/rgb_led_fade_engine_top.sv
// Commands: from accept to table write when idle through pop, read, load and write.
// Tick: pop, then per LED read, load, a check of each channel, the serial divider
// and apply for each moving channel, then write-back; a paused LED skips to write-back.
// Results leave one per LED through a single output register; rsp stalls hold the sweep.
// Reset: synchronous; a clearing pass zeroes every entry of the LED table
// before the first queued item is taken; leds_in_use resets to 32.
`default_nettype none
`include "assert_macros.svh"
module rgb_led_fade_engine_top
   import rlfe_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // led_index, fade_ticks, red, green, blue
   input  wire logic [2:0]  req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // out_led, out_red, out_green, out_blue
   output logic [1:0]       rsp_tuser,  // changed, done_res
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int NW = $clog2(MAX_LEDS + 1);

   logic [LEDCFG_W-1:0] leds_ff;
   logic [NW-1:0]       n_leds;
   logic                q_valid, q_pop;
   item_type            q_item;
   result_type          res;
   back_stat_type       stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         leds_ff <= LEDCFG_W'(LEDS_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == 1'b0)) begin
         leds_ff <= csr_pwdata[LEDCFG_W-1:0];
      end
   end

   assign n_leds     = (CNT_W'(leds_ff) < CNT_W'(MAX_LEDS)) ? NW'(leds_ff) : NW'(MAX_LEDS);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? 32'(leds_ff) : '0;

   rlfe_front #(.NW(NW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .n_leds    (n_leds),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_led    (req_tdata[4:0]),
      .in_ticks  (req_tdata[19:5]),
      .in_col    ({req_tdata[43:36], req_tdata[35:28], req_tdata[27:20]}),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rlfe_back #(.MAX_LEDS(MAX_LEDS), .NW(NW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .n_leds    (n_leds),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res),
      .stat      (stat)
   );

   assign rsp_tdata = {3'b000, res.col[2], res.col[1], res.col[0], res.led};
   assign rsp_tuser = {res.done, res.changed};
   assign rsp_tlast = res.last;

   `ASSERT_IMP(a_no_rsp_in_clear, stat.clearing, !rsp_tvalid)
   `ASSERT_IMP(a_led_in_range, rsp_tvalid, CNT_W'(res.led) < CNT_W'(n_leds))
   `ASSERT_IMP(a_last_is_top, rsp_tvalid && rsp_tlast,
      (CNT_W'(res.led) + CNT_W'(1)) == CNT_W'(n_leds))
   `ASSERT_NEXT(a_pop_leaves_idle, q_pop, stat.busy)

endmodule
`default_nettype wire

// File: tb/tb_rgb_led_fade_engine_top.sv
`default_nettype none
module tb_rgb_led_fade_engine_top;
   import rlfe_pkg::*;

   localparam logic [2:0] ACT_BOGUS_LO = 3'd5;
   localparam logic [2:0] ACT_BOGUS_HI = 3'd7;
   localparam logic       REG_LEDS     = 1'b0;
   localparam int         SETTLE       = 4000;
   localparam int         CYCLE_LIMIT  = 4000000;

   typedef struct {
      logic [2:0] act;
      int         led;
      int         ticks;
      byte unsigned r, g, b;
      bit         chk;
      byte unsigned er, eg, eb;
   } cue_type;

   typedef struct {
      int           led;
      byte unsigned r, g, b;
      bit           changed, done, last;
   } shade_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // led_index, fade_ticks, red, green, blue
   logic [2:0]  req_tuser = '0;  // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // out_led, out_red, out_green, out_blue
   logic [1:0]  rsp_tuser;       // changed, done_res
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic        csr_paddr = 1'b0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rgb_led_fade_engine_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   byte unsigned cur_col[96];
   byte unsigned tgt_col[96];
   int           ch_delta[96];
   int           ch_acc[96];
   int           period[32];
   int           leds_cfg = LEDS_RESET;

   shade_type colour_due[$];
   int     errors = 0;
   int     accepted = 0;
   int     cycles = 0;
   bit     held_off = 0;

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic int lit_count();
      return leds_cfg < 32 ? leds_cfg : 32;
   endfunction

   function automatic bit step_channel(int i, int p);
      int c, d, s, k, m;
      c = cur_col[i];
      d = tgt_col[i];
      if (c == d) return 0;
      s = ch_acc[i] + ch_delta[i];
      if (s < 0) begin
         k = (-s + p - 1) / p;
         if (c > d) begin
            m = (k < c - d) ? k : c - d;
            c -= m;
            s += m * p;
         end else begin
            s += k * p;
         end
      end else if (s >= p) begin
         k = s / p;
         if (c < d) begin
            m = (k < d - c) ? k : d - c;
            c += m;
            s -= m * p;
         end else begin
            s -= k * p;
         end
      end
      if (c == d) s = 0;
      cur_col[i] = 8'(c);
      ch_acc[i] = s;
      return 1;
   endfunction

   task automatic fade_apply(cue_type q);
      int n, i;
      byte unsigned col[3];
      shade_type e;
      bit moving, done;
      n = lit_count();
      col = '{q.r, q.g, q.b};
      if (q.act <= ACT_SET) begin
         if (q.led >= n) return;
         for (int ch = 0; ch < 3; ch++) begin
            i = q.led * 3 + ch;
            case (q.act)
               ACT_FADE, ACT_REDIRECT: begin
                  tgt_col[i] = col[ch];
                  ch_delta[i] = int'(col[ch]) - int'(cur_col[i]);
               end
               ACT_YANK: begin
                  cur_col[i] = col[ch];
                  ch_delta[i] = int'(tgt_col[i]) - int'(col[ch]);
               end
               default: begin
                  cur_col[i] = col[ch];
                  tgt_col[i] = col[ch];
                  ch_delta[i] = 0;
               end
            endcase
         end
         if (q.act == ACT_FADE) period[q.led] = q.ticks < 1 ? 1 : q.ticks;
         return;
      end
      if (q.act != ACT_TICK) return;
      for (int j = 0; j < n; j++) begin
         moving = 0;
         done = 0;
         if (period[j] != 0) begin
            for (int ch = 0; ch < 3; ch++)
               if (step_channel(j * 3 + ch, period[j])) moving = 1;
            if (moving) begin
               done = 1;
               for (int ch = 0; ch < 3; ch++)
                  if (cur_col[j * 3 + ch] != tgt_col[j * 3 + ch]) done = 0;
               if (done)
                  for (int ch = 0; ch < 3; ch++) ch_acc[j * 3 + ch] = 0;
            end
         end
         e.led = j;
         e.r = cur_col[j * 3];
         e.g = cur_col[j * 3 + 1];
         e.b = cur_col[j * 3 + 2];
         e.changed = moving;
         e.done = done;
         e.last = (j + 1 == n);
         if (q.chk && j == q.led) begin
            if (e.r != q.er || e.g != q.eg || e.b != q.eb)
               report_mismatch($sformatf("led %0d predicted %h%h%h, known %h%h%h",
                                         j, e.r, e.g, e.b, q.er, q.eg, q.eb));
            e.r = q.er;
            e.g = q.eg;
            e.b = q.eb;
         end
         colour_due.push_back(e);
      end
   endtask

   task automatic send_beat(cue_type q, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.act;
      req_tdata <= {4'd0, q.b, q.g, q.r, q.ticks[14:0], q.led[4:0]};
      @(posedge clock iff req_tready);
      accepted++;
      fade_apply(q);
   endtask

   function automatic int pick_gap();
      int u;
      u = $urandom_range(0, 99);
      if (u < 55) return 0;
      if (u < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic csr_write(int value);
      logic [31:0] w;
      w = {26'($urandom), 6'(value)};
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_LEDS;
      csr_pwdata <= w;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      leds_cfg = value & 6'h3f;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      if (csr_prdata[5:0] != 6'(value))
         report_mismatch($sformatf("leds_in_use read %0d, wrote %0d", csr_prdata[5:0], value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain_then_write(int value);
      req_tvalid <= 1'b0;
      wait (colour_due.size() == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write(value);
   endtask

   function automatic cue_type random_cue();
      cue_type q;
      int u, n;
      n = lit_count();
      u = $urandom_range(0, 99);
      q.chk = 0;
      if (u < 30) q.act = ACT_TICK;
      else if (u < 58) q.act = ACT_FADE;
      else if (u < 70) q.act = ACT_REDIRECT;
      else if (u < 80) q.act = ACT_YANK;
      else if (u < 92) q.act = ACT_SET;
      else if (u < 96) q.act = ACT_BOGUS_LO;
      else q.act = 3'($urandom_range(5, 7));
      if (n > 0 && $urandom_range(0, 99) < 85) q.led = $urandom_range(0, n - 1);
      else q.led = $urandom_range(0, 31);
      u = $urandom_range(0, 99);
      if (u < 70) q.ticks = $urandom_range(0, 8);
      else if (u < 90) q.ticks = $urandom_range(9, 300);
      else q.ticks = $urandom_range(0, 32767);
      q.r = 8'($urandom);
      q.g = 8'($urandom);
      q.b = 8'($urandom);
      return q;
   endfunction

   // receiver: random back-pressure plus one long hold-off
   initial begin
      int u;
      @(posedge clock iff !reset);
      forever begin
         if (!held_off && accepted >= 40) begin
            held_off = 1;
            rsp_tready <= 1'b0;
            for (int k = 0; k < 700; k++) @(posedge clock);
         end
         u = $urandom_range(0, 99);
         if ((cycles / 3000) % 4 == 1 || u < 60) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (u < 95 ? $urandom_range(1, 3) : $urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      shade_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (colour_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat led %0d", rsp_tdata[4:0]));
         end else begin
            e = colour_due.pop_front();
            if (rsp_tdata[4:0] != e.led[4:0] || rsp_tdata[12:5] != e.r
                || rsp_tdata[20:13] != e.g || rsp_tdata[28:21] != e.b
                || rsp_tuser[0] != e.changed || rsp_tuser[1] != e.done
                || rsp_tlast != e.last)
               report_mismatch($sformatf(
                  "got led %0d %h%h%h c%b d%b l%b, want led %0d %h%h%h c%b d%b l%b",
                  rsp_tdata[4:0], rsp_tdata[12:5], rsp_tdata[20:13], rsp_tdata[28:21],
                  rsp_tuser[0], rsp_tuser[1], rsp_tlast,
                  e.led, e.r, e.g, e.b, e.changed, e.done, e.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   cue_type directed[$];

   function automatic cue_type mk(logic [2:0] a, int led, int t, byte unsigned r, g, b,
                                  bit chk = 0, byte unsigned er = 0, eg = 0, eb = 0);
      cue_type q;
      q = '{a, led, t, r, g, b, chk, er, eg, eb};
      return q;
   endfunction

   initial begin
      int phase_leds[6];
      int wait_cycles;
      for (int i = 0; i < 96; i++) begin
         cur_col[i] = 0;
         tgt_col[i] = 0;
         ch_delta[i] = 0;
         ch_acc[i] = 0;
      end
      for (int i = 0; i < 32; i++) period[i] = 0;

      directed = '{
         mk(ACT_TICK, 0, 0, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00),
         mk(ACT_SET, 31, 0, 8'hff, 8'hff, 8'hff),
         mk(ACT_TICK, 31, 0, 0, 0, 0, 1, 8'hff, 8'hff, 8'hff),
         mk(ACT_FADE, 0, 0, 8'hff, 8'h00, 8'h80),
         mk(ACT_TICK, 0, 0, 0, 0, 0, 1, 8'hff, 8'h00, 8'h80),
         mk(ACT_YANK, 0, 0, 8'h00, 8'hff, 8'h00),
         mk(ACT_REDIRECT, 0, 0, 8'h10, 8'h20, 8'h30),
         mk(ACT_TICK, 0, 0, 0, 0, 0, 1, 8'h10, 8'h20, 8'h30),
         mk(ACT_FADE, 5, 32767, 8'hff, 8'hff, 8'hff),
         mk(ACT_FADE, 7, 3, 8'h09, 8'h00, 8'h00),
         mk(ACT_TICK, 0, 0, 0, 0, 0),
         mk(ACT_TICK, 0, 0, 0, 0, 0),
         mk(ACT_YANK, 7, 0, 8'h00, 8'h00, 8'hff),
         mk(ACT_TICK, 0, 0, 0, 0, 0),
         mk(ACT_REDIRECT, 5, 0, 8'h00, 8'h00, 8'h00),
         mk(ACT_TICK, 0, 0, 0, 0, 0),
         mk(ACT_BOGUS_LO, 3, 1, 8'h55, 8'h55, 8'h55),
         mk(ACT_BOGUS_HI, 3, 1, 8'haa, 8'haa, 8'haa),
         mk(ACT_SET, 2, 0, 8'h00, 8'h00, 8'h00),
         mk(ACT_TICK, 2, 0, 0, 0, 0, 1, 8'h00, 8'h00, 8'h00)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_write(32);
      foreach (directed[i]) send_beat(directed[i], pick_gap());

      // out-of-range index with a single LED in use
      drain_then_write(1);
      send_beat(mk(ACT_SET, 3, 0, 8'h77, 8'h77, 8'h77), 0);
      send_beat(mk(ACT_FADE, 0, 2, 8'h04, 8'h00, 8'hff), 0);
      send_beat(mk(ACT_TICK, 0, 0, 0, 0, 0), 0);

      phase_leds = '{32, 0, 63, 5, 1, 0};
      phase_leds[5] = $urandom_range(1, 63);
      foreach (phase_leds[p]) begin
         drain_then_write(phase_leds[p]);
         for (int k = 0; k < 55; k++) begin
            if ((k / 15) % 3 == 2) send_beat(random_cue(), 0);
            else send_beat(random_cue(), pick_gap());
         end
      end
      req_tvalid <= 1'b0;

      wait (colour_due.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
